// ===== design/char_lcd_bus_writer_macros.svh =====
// Assertion helpers used by the display writer's back end.
`ifndef CHAR_LCD_BUS_WRITER_MACROS_SVH
`define CHAR_LCD_BUS_WRITER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CLBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CLBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/clbw_pkg.sv =====
package clbw_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned PHASE_W = 3;

	localparam logic [15:0] HOLD_TICKS_RESET = 16'd1000;

	localparam logic [1:0] KIND_COMMAND = 2'd0;
	localparam logic [1:0] KIND_CHAR    = 2'd1;
	localparam logic [1:0] KIND_CURSOR  = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	localparam logic [PHASE_W-1:0] PHASE_FIRST     = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_HI_NIBBLE = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_STROBE_LO = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_LO_NIBBLE = 3'd5;
	localparam logic [PHASE_W-1:0] PHASE_LAST_4BIT = 3'd6;
	localparam logic [PHASE_W-1:0] PHASE_LAST_8BIT = 3'd3;

	localparam logic [7:0] CURSOR_CMD_BIT = 8'h80;
	localparam logic [7:0] LOW_HALF_MASK  = 8'h0F;
	localparam logic [7:0] HIGH_HALF_MASK = 8'hF0;

	typedef enum logic [1:0] {
		CFG_FOUR_BIT_BUS   = 2'd0,
		CFG_NIBBLE_UPPER   = 2'd1,
		CFG_HOLD_TICKS     = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SHOW,
		BK_HOLD
	} back_state_t;

	typedef struct packed {
		logic       rs;
		logic [7:0] value;
	} xfer_t;

	typedef struct packed {
		logic        four_bit_bus;
		logic        nibble_on_upper_pins;
		logic [15:0] hold_ticks;
	} cfg_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h00;
			2'd1: base = 8'h40;
			2'd2: base = 8'h10;
			default: base = 8'h50;
		endcase
		return base;
	endfunction

	// Set-DDRAM-address command; base plus column never carries past bit 6.
	function automatic logic [7:0] cursor_cmd(input logic [1:0] row, input logic [3:0] column);
		return (row_base(row) + {4'd0, column}) | CURSOR_CMD_BIT;
	endfunction

	function automatic logic [7:0] place_nibble(input logic [7:0] port, input logic [3:0] nib,
		input logic upper);
		logic [7:0] placed;
		if (upper) begin
			placed = (port & LOW_HALF_MASK) | {nib, 4'd0};
		end else begin
			placed = (port & HIGH_HALF_MASK) | {4'd0, nib};
		end
		return placed;
	endfunction

	// E is low on the first phase and on every phase that closes a strobe.
	function automatic logic phase_enable(input logic [PHASE_W-1:0] phase);
		return (phase != PHASE_FIRST) && (phase != PHASE_STROBE_LO) &&
			(phase != PHASE_LAST_4BIT);
	endfunction

endpackage

// ===== design/clbw_front.sv =====
module clbw_front
	import clbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] byte_value,
	input  logic [1:0] row,
	input  logic [3:0] column,
	output logic       push_valid,
	output xfer_t      push_xfer,
	input  logic       push_ready
);

	logic  valid_s1;
	xfer_t xfer_s1;
	xfer_t xfer_d;
	logic  in_accept;

	assign in_stall   = valid_s1 && !push_ready;
	assign in_accept  = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_xfer  = xfer_s1;

	always_comb begin
		xfer_d.rs = (kind == KIND_CHAR);
		case (kind)
			KIND_CURSOR: xfer_d.value = cursor_cmd(row, column);
			default:     xfer_d.value = byte_value;
		endcase
	end

	// A KIND_NONE request is taken off the channel and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= (kind != KIND_NONE);
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			xfer_s1 <= xfer_d;
		end
	end

endmodule

// ===== design/clbw_queue.sv =====
module clbw_queue
	import clbw_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  xfer_t push_xfer,
	output logic  push_ready,
	output logic  pop_valid,
	output xfer_t pop_xfer,
	input  logic  pop_ready
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(DEPTH - 1);

	xfer_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL_COUNT);
	assign pop_valid  = (count_q != '0);
	assign pop_xfer   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_xfer;
		end
	end

endmodule

// ===== design/clbw_back.sv =====
`include "char_lcd_bus_writer_macros.svh"

module clbw_back
	import clbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pop_valid,
	input  xfer_t      pop_xfer,
	output logic       pop_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reg_select,
	output logic       read_write,
	output logic       enable,
	output logic [7:0] data_pins,
	output logic       last_phase
);

	back_state_t        state_q;
	back_state_t        state_d;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_next;
	logic               en_q;
	logic               last_q;
	logic               rs_q;
	logic [7:0]         port_q;
	logic [7:0]         port_next;
	logic [7:0]         byte_q;
	logic               four_q;
	logic               upper_q;
	logic [15:0]        hold_cnt_q;
	logic               hold_done;
	logic               pop;
	logic               out_accept;
	logic               advance;

	assign hold_done  = (hold_cnt_q <= 16'd1);
	assign pop        = pop_valid && pop_ready;
	assign out_accept = out_valid && !out_stall;
	assign advance    = (state_q == BK_HOLD) && hold_done && !last_q;
	assign phase_next = phase_q + 1'b1;

	assign reg_select = rs_q;
	assign read_write = 1'b0;
	assign enable     = en_q;
	assign data_pins  = port_q;
	assign last_phase = last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = BK_SHOW;
				end
			end
			BK_SHOW: begin
				if (!out_stall) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (hold_done) begin
					state_d = last_q ? BK_IDLE : BK_SHOW;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: pop_ready = 1'b1;
			BK_SHOW: out_valid = 1'b1;
			BK_HOLD: ;
			default: ;
		endcase
	end

	// The port changes only when a new nibble or byte goes onto the pins.
	always_comb begin
		port_next = port_q;
		if (phase_next == PHASE_HI_NIBBLE) begin
			port_next = four_q ? place_nibble(port_q, byte_q[7:4], upper_q) : byte_q;
		end else if (phase_next == PHASE_LO_NIBBLE) begin
			port_next = place_nibble(port_q, byte_q[3:0], upper_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			phase_q <= PHASE_FIRST;
			en_q    <= 1'b0;
			last_q  <= 1'b0;
			rs_q    <= 1'b0;
			port_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				phase_q <= PHASE_FIRST;
				en_q    <= 1'b0;
				last_q  <= 1'b0;
				rs_q    <= pop_xfer.rs;
			end else if (advance) begin
				phase_q <= phase_next;
				en_q    <= phase_enable(phase_next);
				last_q  <= four_q ? (phase_next == PHASE_LAST_4BIT) :
					(phase_next == PHASE_LAST_8BIT);
				port_q  <= port_next;
			end
		end
	end

	// Mode per transfer; user changes configuration only while idle (no check).
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q  <= pop_xfer.value;
			four_q  <= cfg.four_bit_bus;
			upper_q <= cfg.nibble_on_upper_pins;
		end
		if (out_accept) begin
			hold_cnt_q <= cfg.hold_ticks;
		end else if (state_q == BK_HOLD && !hold_done) begin
			hold_cnt_q <= hold_cnt_q - 16'd1;
		end
	end

	`CLBW_ASSERT_NOW(a_last_drops_e, clk, arst_n, out_valid && last_phase, !enable,
		"final phase must leave E low")
	`CLBW_ASSERT_NOW(a_last_at_mode_end, clk, arst_n, out_valid && last_phase,
		(phase_q == (four_q ? PHASE_LAST_4BIT : PHASE_LAST_8BIT)),
		"final phase flagged at the wrong position for the bus mode")
	`CLBW_ASSERT_NEXT(a_pop_starts_transfer, clk, arst_n, pop,
		out_valid && !enable && !last_phase && phase_q == PHASE_FIRST,
		"a new transfer must open with E low at the first phase")
	`CLBW_ASSERT_NOW(a_phase_in_range, clk, arst_n, out_valid,
		(phase_q <= (four_q ? PHASE_LAST_4BIT : PHASE_LAST_8BIT)),
		"phase counter ran past the end of the transfer")

endmodule

// ===== design/char_lcd_bus_writer.sv =====
// Parallel write interface for an HD44780-style character display.
// Input channel (in_valid/in_stall): one request per transfer; kind selects a
// command byte, a display character, or a cursor move to row/column. Kind 3
// is taken and dropped. Configuration (cfg_valid/cfg_ready, always ready):
// index 0 four_bit_bus, 1 nibble_on_upper_pins, 2 hold_ticks; write only when
// no request is in flight.
// Output channel (out_valid/out_stall): one pin snapshot per phase, RS, RW, E,
// the whole data port and a last_phase flag. A transfer is 4 phases on an
// 8-bit bus and 7 phases on a 4-bit bus, high nibble first.
// Timing: a request accepted while the writer is idle passes the front register
// and the queue before its first phase is offered. Each phase is offered on the
// output and, once taken, held while a counter loaded from hold_ticks runs
// down; the writer returns to idle between transfers, and the hold counter
// sets the rate.
// A short queue behind the front register lets new requests be taken while a
// transfer is on the bus.
// Reset clears the queue, drives the port latch and RS low, and restores
// 4-bit mode on the upper pins with a hold of 1000. A stall on the output
// freezes the current snapshot and starts its hold only once it is taken.
module char_lcd_bus_writer
	import clbw_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic [1:0]  row,
	input  logic [3:0]  column,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_select,
	output logic        read_write,
	output logic        enable,
	output logic [7:0]  data_pins,
	output logic        last_phase
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	xfer_t push_xfer;
	logic  pop_valid;
	logic  pop_ready;
	xfer_t pop_xfer;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_bus         <= 1'b1;
			cfg_q.nibble_on_upper_pins <= 1'b1;
			cfg_q.hold_ticks           <= HOLD_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FOUR_BIT_BUS: cfg_q.four_bit_bus         <= cfg_data[0];
				CFG_NIBBLE_UPPER: cfg_q.nibble_on_upper_pins <= cfg_data[0];
				CFG_HOLD_TICKS:   cfg_q.hold_ticks           <= cfg_data;
				default: ;
			endcase
		end
	end

	clbw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.byte_value (byte_value),
		.row        (row),
		.column     (column),
		.push_valid (push_valid),
		.push_xfer  (push_xfer),
		.push_ready (push_ready)
	);

	clbw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_xfer  (push_xfer),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_xfer   (pop_xfer),
		.pop_ready  (pop_ready)
	);

	clbw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_xfer   (pop_xfer),
		.pop_ready  (pop_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.reg_select (reg_select),
		.read_write (read_write),
		.enable     (enable),
		.data_pins  (data_pins),
		.last_phase (last_phase)
	);

endmodule

// ===== verif/char_lcd_bus_writer_checker.sv =====
module char_lcd_bus_writer_checker
	import clbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic [1:0]  row,
	input  logic [3:0]  column,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        reg_select,
	input  logic        read_write,
	input  logic        enable,
	input  logic [7:0]  data_pins,
	input  logic        last_phase,
	input  logic        wrap_up,
	output int          snapshots_pending,
	output int          mismatch_count
);

	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       en;
		logic [7:0] pins;
		logic       last;
	} pin_snapshot_t;

	localparam int PRINT_CAP = 40;

	pin_snapshot_t snapshots_due[$];

	// Our own copy of the writer's registers and pin latches.
	logic        four_bit_q;
	logic        upper_q;
	logic [7:0]  port_q;
	logic        rs_q;
	logic        closed;

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, want));
		end
	endtask

	function automatic logic [7:0] cursor_address(input logic [1:0] r, input logic [3:0] c);
		logic [7:0] offset;
		case (r)
			2'd0: offset = 8'h00;
			2'd1: offset = 8'h40;
			2'd2: offset = 8'h10;
			default: offset = 8'h50;
		endcase
		return (offset + {4'd0, c}) | CURSOR_CMD_BIT;
	endfunction

	// Only the selected half of the port changes; the other half keeps its level.
	function automatic logic [7:0] merge_nibble(input logic [7:0] port, input logic [3:0] nib,
		input logic upper);
		return upper ? {nib, port[3:0]} : {port[7:4], nib};
	endfunction

	task automatic push_phase(input logic en, input logic last);
		snapshots_due.push_back(pin_snapshot_t'{rs_q, 1'b0, en, port_q, last});
	endtask

	task automatic predict_write(input logic [1:0] k, input logic [7:0] b_in,
		input logic [1:0] r, input logic [3:0] c);
		logic [7:0] cmd;
		if (k != KIND_NONE) begin
			cmd = (k == KIND_CURSOR) ? cursor_address(r, c) : b_in;
			rs_q = (k == KIND_CHAR);
			push_phase(1'b0, 1'b0);
			push_phase(1'b1, 1'b0);
			if (four_bit_q) begin
				port_q = merge_nibble(port_q, cmd[7:4], upper_q);
				push_phase(1'b1, 1'b0);
				push_phase(1'b0, 1'b0);
				push_phase(1'b1, 1'b0);
				port_q = merge_nibble(port_q, cmd[3:0], upper_q);
				push_phase(1'b1, 1'b0);
				push_phase(1'b0, 1'b1);
			end else begin
				port_q = cmd;
				push_phase(1'b1, 1'b0);
				push_phase(1'b0, 1'b1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_snapshot_t want;
		if (!arst_n) begin
			snapshots_due.delete();
			four_bit_q = 1'b1;
			upper_q = 1'b1;
			port_q = 8'h00;
			rs_q = 1'b0;
			closed = 1'b0;
			snapshots_pending = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (snapshots_due.size() == 0) begin
					report_mismatch($sformatf("unexpected pin snapshot rs=%b e=%b pins=%0h",
						reg_select, enable, data_pins));
				end else begin
					want = snapshots_due.pop_front();
					check_field("reg_select", {7'd0, reg_select}, {7'd0, want.rs});
					check_field("read_write", {7'd0, read_write}, {7'd0, want.rw});
					check_field("enable", {7'd0, enable}, {7'd0, want.en});
					check_field("data_pins", data_pins, want.pins);
					check_field("last_phase", {7'd0, last_phase}, {7'd0, want.last});
				end
			end
			if (cfg_valid && cfg_ready) begin
				// The hold only sets timing, so it has no copy here.
				case (cfg_index)
					CFG_FOUR_BIT_BUS: four_bit_q = cfg_data[0];
					CFG_NIBBLE_UPPER: upper_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_write(kind, byte_value, row, column);
			end
			if (wrap_up && !closed) begin
				closed = 1'b1;
				if (snapshots_due.size() != 0) begin
					report_mismatch($sformatf("%0d pin snapshots never appeared",
						snapshots_due.size()));
				end
			end
			snapshots_pending = snapshots_due.size();
		end
	end

endmodule

// ===== verif/tb_char_lcd_bus_writer.sv =====
module tb_char_lcd_bus_writer;
	import clbw_pkg::*;

	// The writer has no register behind this index.
	localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
	// Longest quiet stretch: a hold at the largest hold_ticks value plus the settle pause after it.
	localparam int QUIET_LIMIT = 300000;
	localparam int ITEMS_PER_BLOCK = 24;
	localparam int RANDOM_BLOCKS = 6;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [7:0]  byte_value = '0;
	logic [1:0]  row = '0;
	logic [3:0]  column = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        reg_select;
	logic        read_write;
	logic        enable;
	logic [7:0]  data_pins;
	logic        last_phase;
	logic        wrap_up = 1'b0;

	int snapshots_pending;
	int mismatch_count;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_now = int'(HOLD_TICKS_RESET);
	int quiet_cycles = 0;

	char_lcd_bus_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.byte_value(byte_value),
		.row(row),
		.column(column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reg_select(reg_select),
		.read_write(read_write),
		.enable(enable),
		.data_pins(data_pins),
		.last_phase(last_phase)
	);

	char_lcd_bus_writer_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.byte_value(byte_value),
		.row(row),
		.column(column),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reg_select(reg_select),
		.read_write(read_write),
		.enable(enable),
		.data_pins(data_pins),
		.last_phase(last_phase),
		.wrap_up(wrap_up),
		.snapshots_pending(snapshots_pending),
		.mismatch_count(mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == CFG_HOLD_TICKS) begin
			hold_now = int'(value);
		end
	endtask

	task automatic send_request(input logic [1:0] k, input logic [7:0] b,
		input logic [1:0] r, input logic [3:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			kind = 2'($urandom);
			byte_value = 8'($urandom);
			row = 2'($urandom);
			column = 4'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		byte_value = b;
		row = r;
		column = c;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Registers may only change once the writer has finished its last hold.
	task automatic drain();
		in_valid = 1'b0;
		while (snapshots_pending != 0) @(negedge clk);
		repeat (hold_now + 8) @(negedge clk);
	endtask

	initial begin
		logic [1:0] k;
		int counted;
		int pick;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 51;

		// Reset settings: 4-bit on the upper pins, long hold.
		send_request(KIND_COMMAND, 8'h00, 2'd0, 4'd0);
		send_request(KIND_CHAR, 8'hFF, 2'd3, 4'd15);
		send_request(KIND_CURSOR, 8'hFF, 2'd3, 4'd15);
		drain();

		// Lower pins with a zero hold; the spare index must be harmless.
		write_reg(CFG_NIBBLE_UPPER, 16'h0000);
		write_reg(CFG_HOLD_TICKS, 16'd0);
		write_reg(CFG_INDEX_SPARE, 16'hFFFF);
		send_request(KIND_COMMAND, 8'hA5, 2'd0, 4'd0);
		send_request(KIND_CHAR, 8'h5A, 2'd0, 4'd0);
		send_request(KIND_CURSOR, 8'h00, 2'd1, 4'd0);
		send_request(KIND_CURSOR, 8'hFF, 2'd2, 4'd7);
		send_request(KIND_NONE, 8'hFF, 2'd3, 4'd15);
		send_request(KIND_CHAR, 8'h0F, 2'd0, 4'd0);
		drain();

		// Upper bits of a one-bit register are dropped, so this selects 8-bit mode.
		write_reg(CFG_FOUR_BIT_BUS, 16'hFFFE);
		write_reg(CFG_NIBBLE_UPPER, 16'h0001);
		write_reg(CFG_HOLD_TICKS, 16'd1);
		send_request(KIND_COMMAND, 8'h00, 2'd0, 4'd0);
		send_request(KIND_CHAR, 8'hFF, 2'd0, 4'd0);
		send_request(KIND_CURSOR, 8'h00, 2'd0, 4'd0);
		send_request(KIND_NONE, 8'h00, 2'd0, 4'd0);
		send_request(KIND_CHAR, 8'h3C, 2'd1, 4'd9);
		send_request(KIND_CURSOR, 8'h00, 2'd1, 4'd15);
		drain();

		write_reg(CFG_HOLD_TICKS, 16'hFFFF);
		send_request(KIND_CHAR, 8'h81, 2'd0, 4'd0);
		drain();

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk / 2)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(CFG_FOUR_BIT_BUS, 16'($urandom));
			write_reg(CFG_NIBBLE_UPPER, 16'($urandom));
			case ($urandom_range(3))
				0: write_reg(CFG_HOLD_TICKS, 16'd0);
				1: write_reg(CFG_HOLD_TICKS, 16'd1);
				default: write_reg(CFG_HOLD_TICKS, 16'($urandom_range(2, 5)));
			endcase
			counted = 0;
			while (counted < ITEMS_PER_BLOCK) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					k = KIND_NONE;
				end else if (pick < 40) begin
					k = KIND_COMMAND;
				end else if (pick < 70) begin
					k = KIND_CHAR;
				end else begin
					k = KIND_CURSOR;
				end
				send_request(k, 8'($urandom), 2'($urandom), 4'($urandom));
				if (k != KIND_NONE) begin
					counted++;
				end
			end
			drain();
		end

		wrap_up = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/clbw_pkg.sv
design/clbw_front.sv
design/clbw_queue.sv
design/clbw_back.sv
design/char_lcd_bus_writer.sv
verif/char_lcd_bus_writer_checker.sv
verif/tb_char_lcd_bus_writer.sv
